[rtl/core/cflr_pkg.sv]
// Shared types, widths and constants for the CFL time-step reduction unit.
`default_nettype none
package cflr_pkg;

    // Field widths
    localparam int VAL_W    = 31;   // unsigned Q15.16 quantities
    localparam int VEL_W    = 32;   // signed velocity components
    localparam int GAMMA_W  = 19;
    localparam int GP_W     = GAMMA_W + VAL_W;  // gamma * pressure
    localparam int RAD_W    = 64;   // square-root radicand
    localparam int ROOT_W   = RAD_W / 2;
    localparam int IN_W     = 160;  // 158 payload bits rounded up to bytes
    localparam int OUT_W    = 32;
    localparam int CFG_A_W  = 3;

    // Parameter defaults
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_MAX_DIMS  = 3;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_MAX_STEP = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_GAMMA    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_INV_X    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_INV_Y    = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_INV_Z    = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_NUM_DIMS = 3'd5;

    // Register reset values
    localparam logic [VAL_W-1:0]   RST_MAX_STEP = 31'd65536;
    localparam logic [GAMMA_W-1:0] RST_GAMMA    = 19'd109227;
    localparam logic [VAL_W-1:0]   RST_INV      = 31'd65536;
    localparam logic [1:0]         RST_NUM_DIMS = 2'd3;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GAMMA_MUL,
        OP_DIV_C,
        OP_SQRT,
        OP_TAKE_C,
        OP_DIM_MUL,
        OP_DIM_ACC,
        OP_DIV_L,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic den_zero;
        logic sum_zero;
        logic dim_last;
        logic last_cell;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[rtl/core/cflr_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cflr_div #(
    parameter int NUM_W = 50,
    parameter int DVS_W = 49
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DVS_W-1:0] dvs,
    output logic                  busy,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    // trial subtract of the next partial remainder
    assign rem_sh = {rem_reg[DVS_W-1:0], num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            dvs_reg <= dvs;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while still busy");

endmodule
`default_nettype wire

[rtl/core/cflr_sqrt.sv]
// Integer square root, one root bit per cycle.
`default_nettype none
module cflr_sqrt
    import cflr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  rad,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

[rtl/core/cflr_dp.sv]
// Datapath: config registers, operand registers, arithmetic units, result register.
`default_nettype none
module cflr_dp
    import cflr_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int MAX_DIMS  = DEF_MAX_DIMS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [VAL_W-1:0]   cfg_wdata,
    input  wire logic [IN_W-1:0]    s_tdata,
    input  wire logic               s_tlast,
    input  wire op_t                op,
    output sts_t                    sts,
    output logic      [OUT_W-1:0]   m_tdata,
    output logic                    m_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready
);
    localparam int NUM_W = (2 * FRAC_BITS > GP_W) ? 2 * FRAC_BITS : GP_W;
    localparam int DVS_W = VEL_W + VAL_W + 2 - FRAC_BITS;  // holds the sum of terms
    localparam int PRD_W = VEL_W + VAL_W;
    localparam logic [NUM_W-1:0] LIM_NUM = NUM_W'(1) << (2 * FRAC_BITS - 1);

    // configuration
    logic [VAL_W-1:0]   max_step_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [VAL_W-1:0]   inv_x_reg, inv_y_reg, inv_z_reg;
    logic [1:0]         num_dims_reg;

    // cell operands and work registers
    logic [VAL_W-1:0]  pre_reg, den_reg;
    logic [VEL_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic              last_reg;
    logic [GP_W-1:0]   gp_reg;
    logic [VAL_W-1:0]  c_reg;
    logic [1:0]        dim_reg;
    logic [DVS_W-1:0]  sum_reg;
    logic [PRD_W-1:0]  mprod_reg;
    logic [VAL_W-1:0]  rmin_reg;
    logic              flag_reg;
    logic [VAL_W-1:0]  out_ts_reg;
    logic              out_flag_reg;
    logic              out_valid_reg;

    logic [1:0]        nd;
    logic [VEL_W-1:0]  vsel, mag, speed;
    logic [VAL_W-1:0]  isel;
    logic              div_start, div_busy, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DVS_W-1:0]  div_dvs;
    logic [RAD_W-1:0]  c2_w, rad;
    logic              rad_sat;
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  limit;
    logic              out_free;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_step_reg <= RST_MAX_STEP;
            gamma_reg    <= RST_GAMMA;
            inv_x_reg    <= RST_INV;
            inv_y_reg    <= RST_INV;
            inv_z_reg    <= RST_INV;
            num_dims_reg <= RST_NUM_DIMS;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MAX_STEP: max_step_reg <= cfg_wdata;
                REG_GAMMA:    gamma_reg    <= cfg_wdata[GAMMA_W-1:0];
                REG_INV_X:    inv_x_reg    <= cfg_wdata;
                REG_INV_Y:    inv_y_reg    <= cfg_wdata;
                REG_INV_Z:    inv_z_reg    <= cfg_wdata;
                REG_NUM_DIMS: num_dims_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // active axis count, clamped
    always_comb begin
        if (num_dims_reg == 2'd0) begin
            nd = 2'd1;
        end else if (num_dims_reg > MAX_DIMS) begin
            nd = 2'(MAX_DIMS);
        end else begin
            nd = num_dims_reg;
        end
    end

    // per-axis operand select and |v| + c
    always_comb begin
        case (dim_reg)
            2'd0: begin
                vsel = vx_reg;
                isel = inv_x_reg;
            end
            2'd1: begin
                vsel = vy_reg;
                isel = inv_y_reg;
            end
            default: begin
                vsel = vz_reg;
                isel = inv_z_reg;
            end
        endcase
        mag   = vsel[VEL_W-1] ? (~vsel + 1'b1) : vsel;  // most negative gives 2^31
        speed = mag + {1'b0, c_reg};
    end

    // shared divider: gamma*p / rho, then 2^(2F-1) / sum
    assign div_start = (op == OP_DIV_C) || (op == OP_DIV_L);
    assign div_num   = (op == OP_DIV_C) ? NUM_W'(gp_reg) : LIM_NUM;
    assign div_dvs   = (op == OP_DIV_C) ? DVS_W'(den_reg) : sum_reg;

    cflr_div #(
        .NUM_W (NUM_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .dvs     (div_dvs),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    // radicand c2 << F, saturated
    assign c2_w    = RAD_W'(div_quo);
    assign rad_sat = (c2_w >> (RAD_W - FRAC_BITS)) != '0;
    assign rad     = rad_sat ? '1 : (c2_w << FRAC_BITS);

    cflr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (op == OP_SQRT),
        .rad     (rad),
        .done    (sqrt_done),
        .root    (root)
    );

    assign limit    = (sum_reg == '0) ? NUM_W'(max_step_reg >> 1) : div_quo;
    assign out_free = !out_valid_reg || m_tready;

    // operand and work registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                pre_reg  <= s_tdata[30:0];
                den_reg  <= s_tdata[61:31];
                vx_reg   <= s_tdata[93:62];
                vy_reg   <= s_tdata[125:94];
                vz_reg   <= s_tdata[157:126];
                last_reg <= s_tlast;
            end
            OP_GAMMA_MUL: begin
                gp_reg  <= GP_W'(gamma_reg) * GP_W'(pre_reg);
                sum_reg <= '0;
                dim_reg <= 2'd0;
                if (den_reg == '0) begin
                    c_reg <= '1;
                end
            end
            OP_TAKE_C: c_reg <= root[ROOT_W-1] ? '1 : root[VAL_W-1:0];
            OP_DIM_MUL: mprod_reg <= PRD_W'(speed) * PRD_W'(isel);
            OP_DIM_ACC: begin
                sum_reg <= sum_reg + DVS_W'(mprod_reg >> FRAC_BITS);
                dim_reg <= dim_reg + 2'd1;
            end
            OP_EMIT: begin
                out_ts_reg   <= (rmin_reg < max_step_reg) ? rmin_reg : max_step_reg;
                out_flag_reg <= flag_reg;
            end
            default: ;
        endcase
    end

    // running minimum, zero-density flag, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rmin_reg      <= RST_MAX_STEP;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_GAMMA_MUL: begin
                    if (den_reg == '0) begin
                        flag_reg <= 1'b1;
                    end
                end
                OP_UPDATE: begin
                    if (limit < NUM_W'(rmin_reg)) begin
                        rmin_reg <= limit[VAL_W-1:0];
                    end
                end
                OP_EMIT: begin
                    rmin_reg <= max_step_reg;
                    flag_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sts.div_done  = div_done;
        sts.sqrt_done = sqrt_done;
        sts.den_zero  = den_reg == '0;
        sts.sum_zero  = sum_reg == '0;
        sts.dim_last  = dim_reg == (nd - 2'd1);
        sts.last_cell = last_reg;
        sts.out_free  = out_free;
    end

    assign m_tdata  = {1'b0, out_ts_reg};
    assign m_tuser  = out_flag_reg;
    assign m_tvalid = out_valid_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        op == OP_EMIT |-> out_free) else $error("result overwritten before taken");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        op == OP_EMIT |=> out_valid_reg) else $error("emitted result not valid");
    a_div_idle_load: assert property (@(posedge aclk) disable iff (!aresetn)
        op == OP_LOAD |-> !div_busy) else $error("new cell while divider busy");

endmodule
`default_nettype wire

[rtl/core/cflr_ctrl.sv]
// Controller: sequences one cell through the datapath.
`default_nettype none
module cflr_ctrl
    import cflr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output op_t       op
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIVC, S_WDIVC, S_SQRT, S_WSQRT, S_TAKEC,
        S_DMUL, S_DACC, S_LIM, S_WDIVL, S_UPD, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                op         = OP_GAMMA_MUL;
                // zero density skips the division and root
                state_next = sts.den_zero ? S_DMUL : S_DIVC;
            end
            S_DIVC: begin
                op         = OP_DIV_C;
                state_next = S_WDIVC;
            end
            S_WDIVC: if (sts.div_done) state_next = S_SQRT;
            S_SQRT: begin
                op         = OP_SQRT;
                state_next = S_WSQRT;
            end
            S_WSQRT: if (sts.sqrt_done) state_next = S_TAKEC;
            S_TAKEC: begin
                op         = OP_TAKE_C;
                state_next = S_DMUL;
            end
            S_DMUL: begin
                op         = OP_DIM_MUL;
                state_next = S_DACC;
            end
            S_DACC: begin
                op         = OP_DIM_ACC;
                state_next = sts.dim_last ? S_LIM : S_DMUL;
            end
            S_LIM: begin
                if (sts.sum_zero) begin
                    state_next = S_UPD;
                end else begin
                    op         = OP_DIV_L;
                    state_next = S_WDIVL;
                end
            end
            S_WDIVL: if (sts.div_done) state_next = S_UPD;
            S_UPD: begin
                op         = OP_UPDATE;
                state_next = sts.last_cell ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;

endmodule
`default_nettype wire

[rtl/core/cfl_time_step_reduction_unit.sv]
// Top level of the CFL time-step reduction unit.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata (cell fields), s_tlast (last cell)
//  m_       out  m_tvalid/m_tready  m_tdata (time step), m_tuser (zero density)
//  cfg_     in   cfg_we             cfg_addr, cfg_wdata
//
// The time from a cell's acceptance to the next ready, longer on a last cell,
// is set by the shared restoring divider (one quotient bit per cycle, used
// twice) and the 32-step square root. A zero-density cell skips the first
// division and the root; a zero sum skips the second division.
// Reset is synchronous, active low, and reloads config, pass state and control.
// A finished step waits in the output register; a last cell stalls there
// only if the previous step has not been taken.
`default_nettype none
module cfl_time_step_reduction_unit
    import cflr_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int MAX_DIMS  = DEF_MAX_DIMS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [VAL_W-1:0]   cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // pressure, density, velocity_x, velocity_y, velocity_z, zero pad
    input  wire logic [IN_W-1:0]    s_tdata,
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // time_step, zero pad
    output logic      [OUT_W-1:0]   m_tdata,
    // zero_density
    output logic                    m_tuser
);
    op_t  op;
    sts_t sts;

    cflr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .op       (op)
    );

    cflr_dp #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_DIMS  (MAX_DIMS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .op        (op),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the CFL time-step reduction unit.
`timescale 1ns / 100ps
module tb
    import cflr_pkg::*;
();

    localparam int FB = DEF_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [VAL_W-1:0] pressure;
        logic [VAL_W-1:0] density;
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic [VEL_W-1:0] vel_z;
        logic             last;
    } cell_t;

    typedef struct {
        logic [VAL_W-1:0] step;
        logic             zero_den;
    } step_t;

    typedef struct {
        cell_t            cell_in;
        bit               typed;
        logic [VAL_W-1:0] step;
        logic             zero_den;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [VAL_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;

    cfl_time_step_reduction_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    // Shadow registers and pass state of the predictor
    logic [63:0] sh_max_step, sh_gamma, sh_num_dims;
    logic [63:0] sh_inv [3];
    logic [63:0] pass_min;
    logic        pass_zero_den;

    step_t steps_due [$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit hold_req = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Cell limit and pass bookkeeping; returns 1 when the cell closes a pass
    function automatic bit cfl_predict(cell_t c, output step_t s);
        logic [63:0] speed_c, c2, rad, sum, lim, mag, dims;
        logic [VEL_W-1:0] v [3];
        v[0] = c.vel_x; v[1] = c.vel_y; v[2] = c.vel_z;
        dims = (sh_num_dims == 0) ? 1 : sh_num_dims;
        if (c.density == 0) begin
            pass_zero_den = 1'b1;
            speed_c = 64'h7FFF_FFFF;
        end else begin
            c2 = (sh_gamma * 64'(c.pressure)) / 64'(c.density);
            rad = (c2 > (64'hFFFF_FFFF_FFFF_FFFF >> FB)) ? 64'hFFFF_FFFF_FFFF_FFFF : c2 << FB;
            speed_c = int_sqrt(rad);
            if (speed_c > 64'h7FFF_FFFF) speed_c = 64'h7FFF_FFFF;
        end
        sum = 0;
        for (int d = 0; d < 3; d++) begin
            if (d < dims) begin
                // most negative value negates to 2^31 in 64 bits
                mag = v[d][31] ? ((~64'(v[d])) + 1) & 64'hFFFF_FFFF : 64'(v[d]);
                sum += ((mag + speed_c) * sh_inv[d]) >> FB;
            end
        end
        lim = (sum == 0) ? (sh_max_step >> 1) : ((64'd1 << (2 * FB - 1)) / sum);
        if (lim < pass_min) pass_min = lim;
        s.step = '0;
        s.zero_den = 1'b0;
        if (!c.last) return 0;
        s.step = VAL_W'((pass_min < sh_max_step) ? pass_min : sh_max_step);
        s.zero_den = pass_zero_den;
        pass_min = sh_max_step;
        pass_zero_den = 1'b0;
        return 1;
    endfunction

    // One register write, then the write port goes idle before the task returns
    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [VAL_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_STEP: sh_max_step = 64'(val);
            REG_GAMMA:    sh_gamma = 64'(val[GAMMA_W-1:0]);
            REG_INV_X:    sh_inv[0] = 64'(val);
            REG_INV_Y:    sh_inv[1] = 64'(val);
            REG_INV_Z:    sh_inv[2] = 64'(val);
            REG_NUM_DIMS: sh_num_dims = 64'(val[1:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Offer one cell; bursts of back-to-back transactions with random gaps
    task automatic send_cell(cell_t c, bit typed, step_t typed_step);
        step_t s;
        bit ok;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, c.vel_z, c.vel_y, c.vel_x, c.density, c.pressure};
        s_tlast <= c.last;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        if (cfl_predict(c, s)) steps_due.push_back(typed ? typed_step : s);
    endtask

    // Wait for every result, then let the core go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (steps_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_scaled(int hi_bits);
        return $urandom() >> (32 - $urandom_range(1, hi_bits));
    endfunction

    function automatic cell_t random_cell(bit last);
        cell_t c;
        c.pressure = VAL_W'(($urandom_range(0, 3) == 0) ? $urandom() : rand_scaled(31));
        case ($urandom_range(0, 9))
            0: c.density = '0;
            1: c.density = VAL_W'($urandom());
            default: c.density = VAL_W'(rand_scaled(31) | 1);
        endcase
        c.vel_x = ($urandom_range(0, 3) == 0) ? $urandom() : rand_scaled(24) * ($urandom_range(0, 1) ? -1 : 1);
        c.vel_y = ($urandom_range(0, 3) == 0) ? $urandom() : rand_scaled(24) * ($urandom_range(0, 1) ? -1 : 1);
        c.vel_z = ($urandom_range(0, 3) == 0) ? $urandom() : rand_scaled(24) * ($urandom_range(0, 1) ? -1 : 1);
        if ($urandom_range(0, 40) == 0) c.vel_x = 32'h8000_0000;
        c.last = last;
        return c;
    endfunction

    function automatic logic [VAL_W-1:0] rand_inv();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VAL_W'($urandom());
            default: return VAL_W'(rand_scaled(20));
        endcase
    endfunction

    // Receiver: stall pattern, plus one long hold-off on request
    int hold_cnt = 0;
    int ready_mode = 0;
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_cnt = 3000;
            hold_req = 0;
        end
        if ($urandom_range(0, 199) == 0) ready_mode = $urandom_range(0, 3);
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 9) == 0);
                default: m_tready <= ($urandom_range(0, 299) < 30) ? 1'b0 : 1'b1;
            endcase
        end
    end

    // Result check; values are stable at the falling edge before acceptance
    always @(negedge aclk) begin
        step_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (steps_due.size() == 0) begin
                $display("%0t: unexpected result step=%h zero_den=%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                e = steps_due.pop_front();
                if (m_tdata != {1'b0, e.step}) begin
                    $display("%0t: time_step expected %h actual %h", $time, e.step, m_tdata);
                    errors++;
                end
                if (m_tuser != e.zero_den) begin
                    $display("%0t: zero_density expected %b actual %b", $time, e.zero_den, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        row_t rows [$];
        row_t r;
        step_t none;
        int n_sent, plen;
        none.step = '0;
        none.zero_den = 1'b0;

        sh_max_step = 64'(RST_MAX_STEP);
        sh_gamma = 64'(RST_GAMMA);
        for (int d = 0; d < 3; d++) sh_inv[d] = 64'(RST_INV);
        sh_num_dims = 64'(RST_NUM_DIMS);
        pass_min = 64'(RST_MAX_STEP);
        pass_zero_den = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Directed rows under reset settings
        // no pressure, at rest: sum is zero, half the max step
        r.cell_in = '{0, 65536, 0, 0, 0, 1}; r.typed = 1; r.step = 32768; r.zero_den = 0;
        rows.push_back(r);
        // most negative velocity, magnitude 2^31
        r.cell_in = '{0, 1, 32'h8000_0000, 0, 0, 1}; r.typed = 1; r.step = 1; r.zero_den = 0;
        rows.push_back(r);
        // zero density saturates sound speed and flags
        r.cell_in = '{31'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1};
        r.typed = 1; r.step = 0; r.zero_den = 1;
        rows.push_back(r);
        r.typed = 0;
        r.cell_in = '{31'h7FFF_FFFF, 1, 0, 0, 0, 1}; rows.push_back(r);
        r.cell_in = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 1}; rows.push_back(r);
        r.cell_in = '{65536, 65536, 32'h0001_0000, 32'hFFFF_0000, 0, 0}; rows.push_back(r);
        r.cell_in = '{3 << 16, 2 << 16, 32'h0000_8000, 0, 32'hFFF0_0000, 1}; rows.push_back(r);
        // flag carried from an earlier cell of the pass
        r.cell_in = '{1000, 0, 0, 0, 0, 0}; rows.push_back(r);
        r.cell_in = '{5 << 16, 1 << 16, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1};
        rows.push_back(r);
        foreach (rows[i]) begin
            none.step = rows[i].step;
            none.zero_den = rows[i].zero_den;
            send_cell(rows[i].cell_in, rows[i].typed, none);
        end
        drain();

        // max_step changed inside a pass
        send_cell('{2 << 16, 1 << 16, 32'h0000_0100, 0, 0, 0}, 0, none);
        drain();
        write_reg(REG_MAX_STEP, 31'd100);
        send_cell('{0, 1 << 16, 0, 0, 0, 1}, 0, none);
        drain();

        // Low extremes: zero inverse widths, zero dims clamped, minimum gamma and step
        write_reg(REG_MAX_STEP, 31'd1);
        write_reg(REG_GAMMA, 31'd65536);
        write_reg(REG_INV_X, 31'd0);
        write_reg(REG_INV_Y, 31'd0);
        write_reg(REG_INV_Z, 31'd0);
        write_reg(REG_NUM_DIMS, 31'd0);
        write_reg(3'd6, 31'h7FFF_FFFF);
        send_cell('{31'h7FFF_FFFF, 1, 32'h8000_0000, 0, 0, 1}, 0, none);
        send_cell(random_cell(1), 0, none);
        drain();

        // High extremes
        write_reg(REG_MAX_STEP, 31'h7FFF_FFFF);
        write_reg(REG_GAMMA, 31'd327680);
        write_reg(REG_INV_X, 31'h7FFF_FFFF);
        write_reg(REG_INV_Y, 31'h7FFF_FFFF);
        write_reg(REG_INV_Z, 31'h7FFF_FFFF);
        write_reg(REG_NUM_DIMS, 31'd1);
        send_cell('{31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1}, 0, none);
        send_cell('{0, 1, 0, 32'h7FFF_FFFF, 0, 1}, 0, none);
        drain();

        // Random phases, each with its own settings
        n_sent = 0;
        for (int ph = 0; n_sent < 1850; ph++) begin
            case ($urandom_range(0, 4))
                0: write_reg(REG_MAX_STEP, 31'h7FFF_FFFF);
                1: write_reg(REG_MAX_STEP, VAL_W'($urandom()));
                default: write_reg(REG_MAX_STEP, VAL_W'(rand_scaled(22) | 1));
            endcase
            write_reg(REG_GAMMA, VAL_W'($urandom_range(65536, 327680)));
            write_reg(REG_INV_X, rand_inv());
            write_reg(REG_INV_Y, rand_inv());
            write_reg(REG_INV_Z, rand_inv());
            write_reg(REG_NUM_DIMS, VAL_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0) write_reg(3'd7, VAL_W'($urandom()));
            if (ph == 3) hold_req = 1;
            for (int k = 0; k < 120; k += plen) begin
                plen = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 4);
                for (int j = 0; j < plen; j++) send_cell(random_cell(j == plen - 1), 0, none);
                n_sent += plen;
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
